// ----- rtl/core/e2nwa_pkg.sv -----
// Shared constants, codes and control types of the element-to-node weighted average core.
package e2nwa_pkg;

	localparam int unsigned MAX_NODES_DEF      = 1024;
	localparam int unsigned MAX_COMPONENTS_DEF = 4;

	localparam int unsigned OP_W         = 2;
	localparam int unsigned CORNER_W     = 3;
	localparam int unsigned CORNER_IDX_W = 2;
	localparam int unsigned NODE_W       = 10;
	localparam int unsigned COMP_W       = 2;
	localparam int unsigned CCOUNT_W     = 3;
	localparam int unsigned NCOMP_W      = 4;
	localparam int unsigned WEIGHT_W     = 32;
	localparam int unsigned VALUE_W      = 32;
	localparam int unsigned AVG_W        = 32;
	localparam int unsigned SUM_W        = 64;
	localparam int unsigned MASS_W       = 48;

	localparam int unsigned DIV_STEPS = AVG_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [AVG_W-1:0] AVG_POS_MAX = {1'b0, {(AVG_W-1){1'b1}}};
	localparam logic [AVG_W-1:0] AVG_NEG_MIN = {1'b1, {(AVG_W-1){1'b0}}};

	typedef enum logic [OP_W-1:0] {
		OP_ACC   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_NEG,
		ST_RD,
		ST_WR,
		ST_RRD,
		ST_RCHK,
		ST_DIV,
		ST_EMIT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_PREP,
		DV_RUN,
		DV_FIN
	} div_state_t;

	typedef enum logic [1:0] {
		RES_BAD,
		RES_ZERO_MASS,
		RES_NO_COMP,
		RES_AVG
	} res_kind_t;

	typedef struct packed {
		logic      load;
		logic      mul;
		logic      neg;
		logic      corner_inc;
		logic      rd;
		logic      wr;
		logic      div_start;
		logic      clr_step;
		logic      res_load;
		res_kind_t res_kind;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic corners_ok;
		logic comp_ok;
		logic node_ok;
		logic corner_last;
		logic mass_zero;
		logic div_done;
		logic clear_last;
	} dp_sts_t;

endpackage

// ----- rtl/core/e2nwa_if.sv -----
// Request, result and configuration channel interfaces of the weighted average core.
interface e2nwa_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [e2nwa_pkg::OP_W-1:0]           op;
	logic [e2nwa_pkg::CORNER_W-1:0]       corner_count;
	logic [e2nwa_pkg::NODE_W-1:0]         node_a;
	logic [e2nwa_pkg::NODE_W-1:0]         node_b;
	logic [e2nwa_pkg::NODE_W-1:0]         node_c;
	logic [e2nwa_pkg::NODE_W-1:0]         node_d;
	logic [e2nwa_pkg::COMP_W-1:0]         component;
	logic [e2nwa_pkg::WEIGHT_W-1:0]       weight;
	logic signed [e2nwa_pkg::VALUE_W-1:0] element_value;

	modport source (
		output valid, op, corner_count, node_a, node_b, node_c, node_d,
		       component, weight, element_value,
		input  ready
	);
	modport sink (
		input  valid, op, corner_count, node_a, node_b, node_c, node_d,
		       component, weight, element_value,
		output ready
	);
endinterface

interface e2nwa_res_if;
	logic                               valid;
	logic                               ready;
	logic signed [e2nwa_pkg::AVG_W-1:0] node_average;
	logic                               zero_mass;
	logic                               bad_element;

	modport source (output valid, node_average, zero_mass, bad_element, input ready);
	modport sink (input valid, node_average, zero_mass, bad_element, output ready);
endinterface

interface e2nwa_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [e2nwa_pkg::CCOUNT_W-1:0]   component_count;

	modport source (output valid, component_count, input ready);
	modport sink (input valid, component_count, output ready);
endinterface

// ----- rtl/core/element_to_node_weighted_average_core.sv -----
// Top level of the element-to-node weighted average core: controller and datapath.
//
//  Channel | Role   | Handshake   | Carries
//  --------+--------+-------------+-----------------------------------------------------
//  req     | sink   | valid/ready | op, corners, four node indices, component, weight, value
//  res     | source | valid/ready | node_average, zero_mass, bad_element
//  cfg     | sink   | valid/ready | component_count (always ready)
//
// Requests are handled one at a time. An accumulate request does one read-modify-write of
// the sum store per corner inside the store, and of the mass store for component 0; other
// corners are skipped. A read with nonzero mass and a valid component uses the 32-step
// divider. After reset and for every clear request the stores are swept one sum entry a
// cycle over all MAX_NODES * 2**COMP_AW entries (4096 by default), with req held off.
// One result register decouples res: the next request is taken while a result waits.
module element_to_node_weighted_average_core #(
	parameter int unsigned MAX_NODES      = e2nwa_pkg::MAX_NODES_DEF,
	parameter int unsigned MAX_COMPONENTS = e2nwa_pkg::MAX_COMPONENTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	e2nwa_req_if.sink  req,
	e2nwa_res_if.source res,
	e2nwa_cfg_if.sink  cfg
);

	e2nwa_pkg::dp_cmd_t cmd;
	e2nwa_pkg::dp_sts_t sts;

	assign cfg.ready = 1'b1;

	e2nwa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	e2nwa_dp #(
		.MAX_NODES      (MAX_NODES),
		.MAX_COMPONENTS (MAX_COMPONENTS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg.valid),
		.cfg_count         (cfg.component_count),
		.req_op            (req.op),
		.req_corner_count  (req.corner_count),
		.req_node_a        (req.node_a),
		.req_node_b        (req.node_b),
		.req_node_c        (req.node_c),
		.req_node_d        (req.node_d),
		.req_component     (req.component),
		.req_weight        (req.weight),
		.req_element_value (req.element_value),
		.cmd               (cmd),
		.sts               (sts),
		.node_average      (res.node_average),
		.zero_mass         (res.zero_mass),
		.bad_element       (res.bad_element)
	);

endmodule

// ----- rtl/core/e2nwa_div.sv -----
// Sequential restoring divider: signed Q32.32 sum by unsigned Q32.16 mass, saturated Q16.16.
module e2nwa_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [e2nwa_pkg::SUM_W-1:0]       sum,
	input  logic [e2nwa_pkg::MASS_W-1:0]      mass,
	output logic                              done,
	output logic [e2nwa_pkg::AVG_W-1:0]       quot
);

	localparam int unsigned SW = e2nwa_pkg::SUM_W;
	localparam int unsigned MW = e2nwa_pkg::MASS_W;
	localparam int unsigned QW = e2nwa_pkg::AVG_W;
	localparam int unsigned CW = e2nwa_pkg::DIV_CNT_W;

	e2nwa_pkg::div_state_t state_q, state_d;

	logic          neg_q;
	logic          ovf_q;
	logic [SW-1:0] mag_q;
	logic [MW-1:0] mass_q;
	logic [MW-1:0] rem_q;
	logic [QW-1:0] low_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [QW-1:0] quot_q;

	logic          load_en;
	logic          prep_en;
	logic          run_en;
	logic          fin_en;
	logic          ovf;
	logic          cnt_last;
	logic [MW:0]   trial;
	logic          ge;
	logic [MW-1:0] rem_nx;
	logic [QW-1:0] sat_val;

	// The quotient fits in QW bits exactly when the upper half of the magnitude is below the mass.
	assign ovf      = MW'(mag_q[SW-1:QW]) >= mass_q;
	assign cnt_last = cnt_q == CW'(e2nwa_pkg::DIV_STEPS - 1);
	assign trial    = {rem_q, low_q[QW-1]};
	assign ge       = trial >= {1'b0, mass_q};
	assign rem_nx   = ge ? MW'(trial - {1'b0, mass_q}) : trial[MW-1:0];

	always_comb begin
		if (ovf_q) begin
			sat_val = neg_q ? e2nwa_pkg::AVG_NEG_MIN : e2nwa_pkg::AVG_POS_MAX;
		end else if (neg_q) begin
			sat_val = low_q[QW-1] ? e2nwa_pkg::AVG_NEG_MIN : (~low_q + 1'b1);
		end else begin
			sat_val = low_q[QW-1] ? e2nwa_pkg::AVG_POS_MAX : low_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			e2nwa_pkg::DV_IDLE: begin
				if (start) begin
					state_d = e2nwa_pkg::DV_PREP;
				end
			end
			e2nwa_pkg::DV_PREP: begin
				state_d = ovf ? e2nwa_pkg::DV_FIN : e2nwa_pkg::DV_RUN;
			end
			e2nwa_pkg::DV_RUN: begin
				if (cnt_last) begin
					state_d = e2nwa_pkg::DV_FIN;
				end
			end
			e2nwa_pkg::DV_FIN: begin
				state_d = e2nwa_pkg::DV_IDLE;
			end
			default: begin
				state_d = e2nwa_pkg::DV_IDLE;
			end
		endcase
	end

	always_comb begin
		load_en = 1'b0;
		prep_en = 1'b0;
		run_en  = 1'b0;
		fin_en  = 1'b0;
		case (state_q)
			e2nwa_pkg::DV_IDLE: load_en = start;
			e2nwa_pkg::DV_PREP: prep_en = 1'b1;
			e2nwa_pkg::DV_RUN:  run_en  = 1'b1;
			e2nwa_pkg::DV_FIN:  fin_en  = 1'b1;
			default: begin
				load_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= e2nwa_pkg::DV_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= fin_en;
			if (prep_en) begin
				cnt_q <= '0;
			end else if (run_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			neg_q  <= sum[SW-1];
			mag_q  <= sum[SW-1] ? (~sum + 1'b1) : sum;
			mass_q <= mass;
		end
		if (prep_en) begin
			ovf_q <= ovf;
			rem_q <= MW'(mag_q[SW-1:QW]);
			low_q <= mag_q[QW-1:0];
		end
		if (run_en) begin
			rem_q <= rem_nx;
			low_q <= {low_q[QW-2:0], ge};
		end
		if (fin_en) begin
			quot_q <= sat_val;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	a_rem_below_mass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == e2nwa_pkg::DV_RUN) |-> (rem_q < mass_q))
		else $error("divider remainder reached the divisor");

	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == e2nwa_pkg::DV_FIN))
		else $error("divider done without a final step");

endmodule

// ----- rtl/core/e2nwa_dp.sv -----
// Datapath: request registers, product, node stores with update logic, divider and result register.
module e2nwa_dp #(
	parameter int unsigned MAX_NODES      = e2nwa_pkg::MAX_NODES_DEF,
	parameter int unsigned MAX_COMPONENTS = e2nwa_pkg::MAX_COMPONENTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [e2nwa_pkg::CCOUNT_W-1:0]       cfg_count,
	input  logic [e2nwa_pkg::OP_W-1:0]           req_op,
	input  logic [e2nwa_pkg::CORNER_W-1:0]       req_corner_count,
	input  logic [e2nwa_pkg::NODE_W-1:0]         req_node_a,
	input  logic [e2nwa_pkg::NODE_W-1:0]         req_node_b,
	input  logic [e2nwa_pkg::NODE_W-1:0]         req_node_c,
	input  logic [e2nwa_pkg::NODE_W-1:0]         req_node_d,
	input  logic [e2nwa_pkg::COMP_W-1:0]         req_component,
	input  logic [e2nwa_pkg::WEIGHT_W-1:0]       req_weight,
	input  logic signed [e2nwa_pkg::VALUE_W-1:0] req_element_value,
	input  e2nwa_pkg::dp_cmd_t                   cmd,
	output e2nwa_pkg::dp_sts_t                   sts,
	output logic signed [e2nwa_pkg::AVG_W-1:0]   node_average,
	output logic                                 zero_mass,
	output logic                                 bad_element
);

	localparam int unsigned SW        = e2nwa_pkg::SUM_W;
	localparam int unsigned MW        = e2nwa_pkg::MASS_W;
	localparam int unsigned WW        = e2nwa_pkg::WEIGHT_W;
	localparam int unsigned VW        = e2nwa_pkg::VALUE_W;
	localparam int unsigned AW        = e2nwa_pkg::AVG_W;
	localparam int unsigned NODE_AW   = $clog2(MAX_NODES);
	localparam int unsigned COMP_AW   = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int unsigned SUM_AW    = NODE_AW + COMP_AW;
	localparam int unsigned SUM_DEPTH = MAX_NODES * (2 ** COMP_AW);

	function automatic logic [SW-1:0] sat_add_sum(input logic [SW-1:0] a,
	                                              input logic [SW-1:0] b);
		logic [SW-1:0] r;
		r = a + b;
		if ((a[SW-1] == b[SW-1]) && (r[SW-1] != a[SW-1])) begin
			r = a[SW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic [MW-1:0] sat_add_mass(input logic [MW-1:0] m,
	                                               input logic [WW-1:0] w);
		logic [MW:0] r;
		r = {1'b0, m} + (MW+1)'(w);
		return r[MW] ? {MW{1'b1}} : r[MW-1:0];
	endfunction

	// Request registers.
	e2nwa_pkg::op_t                          op_q;
	logic [e2nwa_pkg::CORNER_W-1:0]          corners_q;
	logic [e2nwa_pkg::NODE_W-1:0]            node_q [4];
	logic [e2nwa_pkg::COMP_W-1:0]            comp_q;
	logic [WW-1:0]                           weight_q;
	logic [VW-1:0]                           mag_q;
	logic                                    neg_q;
	logic [SW-1:0]                           prod_q;

	logic [e2nwa_pkg::CCOUNT_W-1:0]          ccount_q;
	logic [e2nwa_pkg::CORNER_IDX_W-1:0]      corner_q;
	logic [SUM_AW-1:0]                       clr_q;

	logic [SW-1:0] sum_mem  [SUM_DEPTH];
	logic [MW-1:0] mass_mem [MAX_NODES];
	logic [SW-1:0] sum_rd_q;
	logic [MW-1:0] mass_rd_q;

	logic [AW-1:0] avg_q;
	logic          zm_q;
	logic          bad_q;

	logic [e2nwa_pkg::NCOMP_W-1:0] ncomp_eff;
	logic [e2nwa_pkg::NODE_W-1:0]  node_cur;
	logic [NODE_AW-1:0]            node_addr;
	logic [COMP_AW-1:0]            comp_idx;
	logic [SUM_AW-1:0]             sum_addr;
	logic                          clear_last;
	logic                          sum_we;
	logic [SUM_AW-1:0]             sum_wa;
	logic [SW-1:0]                 sum_wd;
	logic                          mass_we;
	logic [NODE_AW-1:0]            mass_wa;
	logic [MW-1:0]                 mass_wd;
	logic                          div_done;
	logic [AW-1:0]                 div_quot;
	logic [VW-1:0]                 value_u;

	// A count of zero behaves as one, and a count beyond the store's columns is clipped.
	always_comb begin
		if (ccount_q == '0) begin
			ncomp_eff = e2nwa_pkg::NCOMP_W'(1);
		end else if (32'(ccount_q) > MAX_COMPONENTS) begin
			ncomp_eff = e2nwa_pkg::NCOMP_W'(MAX_COMPONENTS);
		end else begin
			ncomp_eff = e2nwa_pkg::NCOMP_W'(ccount_q);
		end
	end

	assign value_u    = $unsigned(req_element_value);
	assign node_cur   = node_q[corner_q];
	assign node_addr  = NODE_AW'(32'(node_cur));
	assign comp_idx   = COMP_AW'(32'(comp_q));
	assign sum_addr   = {node_addr, comp_idx};
	assign clear_last = clr_q == SUM_AW'(SUM_DEPTH - 1);

	assign sts.op          = op_q;
	assign sts.corners_ok  = (corners_q == 3'd2) || (corners_q == 3'd3) || (corners_q == 3'd4);
	assign sts.comp_ok     = e2nwa_pkg::NCOMP_W'(comp_q) < ncomp_eff;
	assign sts.node_ok     = 32'(node_cur) < MAX_NODES;
	assign sts.corner_last = (e2nwa_pkg::CORNER_W'(corner_q) + 1'b1) == corners_q;
	assign sts.mass_zero   = mass_rd_q == '0;
	assign sts.div_done    = div_done;
	assign sts.clear_last  = clear_last;

	assign sum_we  = cmd.wr | cmd.clr_step;
	assign sum_wa  = cmd.clr_step ? clr_q : sum_addr;
	assign sum_wd  = cmd.clr_step ? '0 : sat_add_sum(sum_rd_q, prod_q);
	assign mass_we = cmd.clr_step | (cmd.wr & (comp_q == '0));
	assign mass_wa = cmd.clr_step ? clr_q[SUM_AW-1:COMP_AW] : node_addr;
	assign mass_wd = cmd.clr_step ? '0 : sat_add_mass(mass_rd_q, weight_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ccount_q <= e2nwa_pkg::CCOUNT_W'(1);
			corner_q <= '0;
			clr_q    <= '0;
		end else begin
			if (cfg_we) begin
				ccount_q <= cfg_count;
			end
			if (cmd.load) begin
				corner_q <= '0;
			end else if (cmd.corner_inc) begin
				corner_q <= corner_q + 1'b1;
			end
			if (cmd.clr_step) begin
				clr_q <= clear_last ? '0 : clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= e2nwa_pkg::op_t'(req_op);
			corners_q <= req_corner_count;
			node_q[0] <= req_node_a;
			node_q[1] <= req_node_b;
			node_q[2] <= req_node_c;
			node_q[3] <= req_node_d;
			comp_q    <= req_component;
			weight_q  <= req_weight;
			neg_q     <= value_u[VW-1];
			mag_q     <= value_u[VW-1] ? (~value_u + 1'b1) : value_u;
		end
		// Magnitude product first, sign applied in the following step.
		if (cmd.mul) begin
			prod_q <= SW'(mag_q) * SW'(weight_q);
		end else if (cmd.neg) begin
			prod_q <= neg_q ? (~prod_q + 1'b1) : prod_q;
		end
	end

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[sum_wa] <= sum_wd;
		end
		if (cmd.rd) begin
			sum_rd_q <= sum_mem[sum_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (mass_we) begin
			mass_mem[mass_wa] <= mass_wd;
		end
		if (cmd.rd) begin
			mass_rd_q <= mass_mem[node_addr];
		end
	end

	e2nwa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.sum    (sum_rd_q),
		.mass   (mass_rd_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			case (cmd.res_kind)
				e2nwa_pkg::RES_BAD: begin
					avg_q <= '0;
					zm_q  <= 1'b0;
					bad_q <= 1'b1;
				end
				e2nwa_pkg::RES_ZERO_MASS: begin
					avg_q <= '0;
					zm_q  <= 1'b1;
					bad_q <= 1'b0;
				end
				e2nwa_pkg::RES_AVG: begin
					avg_q <= div_quot;
					zm_q  <= 1'b0;
					bad_q <= 1'b0;
				end
				default: begin
					avg_q <= '0;
					zm_q  <= 1'b0;
					bad_q <= 1'b0;
				end
			endcase
		end
	end

	assign node_average = $signed(avg_q);
	assign zero_mass    = zm_q;
	assign bad_element  = bad_q;

	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> $past(cmd.rd))
		else $error("store update without its read");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> sts.node_ok)
		else $error("store update at a node outside the store");

endmodule

// ----- rtl/core/e2nwa_ctrl.sv -----
// Controller state machine: sequences accumulate, read and clear requests over the datapath.
module e2nwa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 res_valid,
	input  logic                 res_ready,
	input  e2nwa_pkg::dp_sts_t   sts,
	output e2nwa_pkg::dp_cmd_t   cmd
);

	e2nwa_pkg::ctrl_state_t state_q, state_d;
	e2nwa_pkg::res_kind_t   kind_q, kind_d;
	logic                   out_valid_q;
	logic                   slot_free;

	assign slot_free = !out_valid_q || res_ready;

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		case (state_q)
			e2nwa_pkg::ST_CLEAR: begin
				if (sts.clear_last) begin
					state_d = e2nwa_pkg::ST_IDLE;
				end
			end
			e2nwa_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = e2nwa_pkg::ST_DECODE;
				end
			end
			e2nwa_pkg::ST_DECODE: begin
				case (sts.op)
					e2nwa_pkg::OP_ACC: begin
						if (!sts.corners_ok) begin
							kind_d  = e2nwa_pkg::RES_BAD;
							state_d = e2nwa_pkg::ST_EMIT;
						end else if (!sts.comp_ok) begin
							state_d = e2nwa_pkg::ST_IDLE;
						end else begin
							state_d = e2nwa_pkg::ST_MUL;
						end
					end
					e2nwa_pkg::OP_READ:  state_d = e2nwa_pkg::ST_RRD;
					e2nwa_pkg::OP_CLEAR: state_d = e2nwa_pkg::ST_CLEAR;
					default:             state_d = e2nwa_pkg::ST_IDLE;
				endcase
			end
			e2nwa_pkg::ST_MUL: state_d = e2nwa_pkg::ST_NEG;
			e2nwa_pkg::ST_NEG: state_d = e2nwa_pkg::ST_RD;
			e2nwa_pkg::ST_RD: begin
				if (sts.node_ok) begin
					state_d = e2nwa_pkg::ST_WR;
				end else if (sts.corner_last) begin
					state_d = e2nwa_pkg::ST_IDLE;
				end
			end
			e2nwa_pkg::ST_WR: begin
				state_d = sts.corner_last ? e2nwa_pkg::ST_IDLE : e2nwa_pkg::ST_RD;
			end
			e2nwa_pkg::ST_RRD: state_d = e2nwa_pkg::ST_RCHK;
			e2nwa_pkg::ST_RCHK: begin
				if (!sts.node_ok || sts.mass_zero) begin
					kind_d  = e2nwa_pkg::RES_ZERO_MASS;
					state_d = e2nwa_pkg::ST_EMIT;
				end else if (!sts.comp_ok) begin
					kind_d  = e2nwa_pkg::RES_NO_COMP;
					state_d = e2nwa_pkg::ST_EMIT;
				end else begin
					state_d = e2nwa_pkg::ST_DIV;
				end
			end
			e2nwa_pkg::ST_DIV: begin
				if (sts.div_done) begin
					kind_d  = e2nwa_pkg::RES_AVG;
					state_d = e2nwa_pkg::ST_EMIT;
				end
			end
			e2nwa_pkg::ST_EMIT: begin
				if (slot_free) begin
					state_d = e2nwa_pkg::ST_IDLE;
				end
			end
			default: state_d = e2nwa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.res_kind = kind_q;
		req_ready    = 1'b0;
		case (state_q)
			e2nwa_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
			e2nwa_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			e2nwa_pkg::ST_MUL: cmd.mul = 1'b1;
			e2nwa_pkg::ST_NEG: cmd.neg = 1'b1;
			e2nwa_pkg::ST_RD: begin
				// A corner outside the store is skipped without a store access.
				cmd.rd         = sts.node_ok;
				cmd.corner_inc = !sts.node_ok && !sts.corner_last;
			end
			e2nwa_pkg::ST_WR: begin
				cmd.wr         = 1'b1;
				cmd.corner_inc = !sts.corner_last;
			end
			e2nwa_pkg::ST_RRD: cmd.rd = 1'b1;
			e2nwa_pkg::ST_RCHK: begin
				cmd.div_start = sts.node_ok && !sts.mass_zero && sts.comp_ok;
			end
			e2nwa_pkg::ST_EMIT: cmd.res_load = slot_free;
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= e2nwa_pkg::ST_CLEAR;
			kind_q      <= e2nwa_pkg::RES_BAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || res_ready))
		else $error("result loaded over one not yet taken");

	a_div_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == e2nwa_pkg::ST_DIV && !sts.div_done) |=> (state_q == e2nwa_pkg::ST_DIV))
		else $error("read left the divide before it finished");

endmodule

// ----- sim/element_to_node_weighted_average_core_test.sv -----
// Self-checking testbench of the element-to-node weighted average core.
module element_to_node_weighted_average_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [e2nwa_pkg::OP_W-1:0] OP_SPARE = 2'd3;
	localparam logic [63:0]     SUM_POS   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0]     SUM_NEG   = 64'h8000_0000_0000_0000;
	localparam logic [48:0]     MASS_TOP  = 49'h0_FFFF_FFFF_FFFF;
	localparam int unsigned     HOLD_LEN  = 300;
	localparam int unsigned     PHASE_LEN = 135;

	typedef struct packed {
		logic [e2nwa_pkg::OP_W-1:0]     op;
		logic [e2nwa_pkg::CORNER_W-1:0] corner_count;
		logic [e2nwa_pkg::NODE_W-1:0]   node_a;
		logic [e2nwa_pkg::NODE_W-1:0]   node_b;
		logic [e2nwa_pkg::NODE_W-1:0]   node_c;
		logic [e2nwa_pkg::NODE_W-1:0]   node_d;
		logic [e2nwa_pkg::COMP_W-1:0]   component;
		logic [e2nwa_pkg::WEIGHT_W-1:0] weight;
		logic [e2nwa_pkg::VALUE_W-1:0]  element_value;
	} request_t;

	typedef struct packed {
		logic [e2nwa_pkg::AVG_W-1:0] node_average;
		logic                        zero_mass;
		logic                        bad_element;
	} average_t;

	localparam int unsigned REQ_BITS = $bits(request_t);

	logic clk;
	logic arst_n;

	e2nwa_req_if req_ch();
	e2nwa_res_if res_ch();
	e2nwa_cfg_if cfg_ch();

	element_to_node_weighted_average_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// Own copy of the node stores and the component count register.
	logic [e2nwa_pkg::MASS_W-1:0]   mass_store [e2nwa_pkg::MAX_NODES_DEF];
	logic [e2nwa_pkg::SUM_W-1:0]    sum_store [e2nwa_pkg::MAX_NODES_DEF*e2nwa_pkg::MAX_COMPONENTS_DEF];
	logic [e2nwa_pkg::CCOUNT_W-1:0] model_ccount;

	request_t    queued_requests[$];
	average_t    due_averages[$];
	request_t    on_bus;
	int unsigned requests_queued;
	int unsigned requests_taken;
	int unsigned mismatches;
	int unsigned src_gap;
	int unsigned sink_gap;
	int unsigned stall_left;
	bit          hold_done;
	logic        gaps_on;
	logic        long_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic void clear_node_stores();
		foreach (mass_store[n]) mass_store[n] = '0;
		foreach (sum_store[s]) sum_store[s] = '0;
	endfunction

	// Applies one accepted request to the stores and queues the result it causes.
	function automatic void update_node_stores(input request_t rq);
		logic [2:0]        ncomp;
		logic signed [63:0] value_wide;
		logic signed [63:0] weight_wide;
		logic [63:0]        product;
		logic [63:0]        total;
		logic [63:0]        magnitude;
		logic [63:0]        quotient;
		logic [48:0]        mass_sum;
		logic [e2nwa_pkg::NODE_W-1:0] nd;
		average_t           outcome;
		if (model_ccount == 3'd0)
			ncomp = 3'd1;
		else if (model_ccount > 3'(e2nwa_pkg::MAX_COMPONENTS_DEF))
			ncomp = 3'(e2nwa_pkg::MAX_COMPONENTS_DEF);
		else
			ncomp = model_ccount;
		case (rq.op)
			e2nwa_pkg::OP_ACC: begin
				if (rq.corner_count < 3'd2 || rq.corner_count > 3'd4) begin
					outcome = '{node_average: '0, zero_mass: 1'b0, bad_element: 1'b1};
					due_averages.push_back(outcome);
				end else if ({1'b0, rq.component} < ncomp) begin
					value_wide = {{32{rq.element_value[31]}}, rq.element_value};
					weight_wide = {32'd0, rq.weight};
					product = value_wide * weight_wide;
					for (int i = 0; i < int'(rq.corner_count); i++) begin
						case (i)
							0: nd = rq.node_a;
							1: nd = rq.node_b;
							2: nd = rq.node_c;
							default: nd = rq.node_d;
						endcase
						total = sum_store[{nd, rq.component}] + product;
						if (sum_store[{nd, rq.component}][63] == product[63] &&
						    total[63] != product[63])
							total = product[63] ? SUM_NEG : SUM_POS;
						sum_store[{nd, rq.component}] = total;
						if (rq.component == '0) begin
							mass_sum = {1'b0, mass_store[nd]} + {17'd0, rq.weight};
							mass_store[nd] = (mass_sum > MASS_TOP) ? MASS_TOP[47:0]
							                                       : mass_sum[47:0];
						end
					end
				end
			end
			e2nwa_pkg::OP_READ: begin
				nd = rq.node_a;
				outcome = '{node_average: '0, zero_mass: 1'b0, bad_element: 1'b0};
				if (mass_store[nd] == '0) begin
					outcome.zero_mass = 1'b1;
				end else if ({1'b0, rq.component} < ncomp) begin
					total = sum_store[{nd, rq.component}];
					magnitude = total[63] ? (64'd0 - total) : total;
					quotient = magnitude / {16'd0, mass_store[nd]};
					if (total[63]) begin
						if (quotient >= 64'h8000_0000)
							outcome.node_average = e2nwa_pkg::AVG_NEG_MIN;
						else begin
							quotient = 64'd0 - quotient;
							outcome.node_average = quotient[31:0];
						end
					end else begin
						outcome.node_average = (quotient > 64'h7FFF_FFFF)
						                       ? e2nwa_pkg::AVG_POS_MAX : quotient[31:0];
					end
				end
				due_averages.push_back(outcome);
			end
			e2nwa_pkg::OP_CLEAR: clear_node_stores();
			default: ;
		endcase
	endfunction

	// Request driver: one request on the bus at a time, with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.op <= '0;
			req_ch.corner_count <= '0;
			req_ch.node_a <= '0;
			req_ch.node_b <= '0;
			req_ch.node_c <= '0;
			req_ch.node_d <= '0;
			req_ch.component <= '0;
			req_ch.weight <= '0;
			req_ch.element_value <= '0;
			src_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				update_node_stores(on_bus);
				requests_taken++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (src_gap != 0) begin
					src_gap--;
					req_ch.valid <= 1'b0;
				end else if (gaps_on && queued_requests.size() != 0 &&
				             $urandom_range(0, 5) == 0) begin
					src_gap = $urandom_range(0, 4);
					req_ch.valid <= 1'b0;
				end else if (queued_requests.size() != 0) begin
					on_bus = queued_requests.pop_front();
					req_ch.op <= on_bus.op;
					req_ch.corner_count <= on_bus.corner_count;
					req_ch.node_a <= on_bus.node_a;
					req_ch.node_b <= on_bus.node_b;
					req_ch.node_c <= on_bus.node_c;
					req_ch.node_d <= on_bus.node_d;
					req_ch.component <= on_bus.component;
					req_ch.weight <= on_bus.weight;
					req_ch.element_value <= on_bus.element_value;
					req_ch.valid <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each result and drives ready with stalls.
	always @(posedge clk or negedge arst_n) begin
		average_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			sink_gap = 0;
			stall_left = 0;
			hold_done = 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (due_averages.size() == 0) begin
					report_mismatch("result arrived with no request awaiting one");
				end else begin
					want = due_averages.pop_front();
					if (res_ch.node_average !== want.node_average)
						report_mismatch($sformatf("node_average %h, expected %h",
						                          res_ch.node_average, want.node_average));
					if (res_ch.zero_mass !== want.zero_mass)
						report_mismatch($sformatf("zero_mass %b, expected %b",
						                          res_ch.zero_mass, want.zero_mass));
					if (res_ch.bad_element !== want.bad_element)
						report_mismatch($sformatf("bad_element %b, expected %b",
						                          res_ch.bad_element, want.bad_element));
				end
			end
			if (long_hold && !hold_done) begin
				hold_done = 1'b1;
				stall_left = HOLD_LEN;
			end
			if (stall_left != 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (sink_gap != 0) begin
				sink_gap--;
				res_ch.ready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				sink_gap = $urandom_range(0, 4);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	function automatic request_t build_request(
		input logic [e2nwa_pkg::OP_W-1:0]     op,
		input logic [e2nwa_pkg::CORNER_W-1:0] corners,
		input logic [e2nwa_pkg::NODE_W-1:0]   a,
		input logic [e2nwa_pkg::NODE_W-1:0]   b,
		input logic [e2nwa_pkg::NODE_W-1:0]   c,
		input logic [e2nwa_pkg::NODE_W-1:0]   d,
		input logic [e2nwa_pkg::COMP_W-1:0]   comp,
		input logic [e2nwa_pkg::WEIGHT_W-1:0] weight,
		input logic [e2nwa_pkg::VALUE_W-1:0]  value
	);
		request_t rq;
		rq = '{op: op, corner_count: corners, node_a: a, node_b: b, node_c: c, node_d: d,
		       component: comp, weight: weight, element_value: value};
		return rq;
	endfunction

	task automatic queue_request(input request_t rq);
		queued_requests.push_back(rq);
		requests_queued++;
	endtask

	function automatic logic [e2nwa_pkg::NODE_W-1:0] pick_node();
		if ($urandom_range(0, 99) < 85)
			return e2nwa_pkg::NODE_W'($urandom_range(0, 15));
		return e2nwa_pkg::NODE_W'($urandom_range(0, 1023));
	endfunction

	function automatic logic [e2nwa_pkg::WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return $urandom;
			default: return $urandom_range(1, 32'h0004_0000);
		endcase
	endfunction

	function automatic logic [e2nwa_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2, 3: return $urandom;
			default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
		endcase
	endfunction

	// Mostly well-formed element and read requests on a small node pool.
	task automatic queue_random_requests(input int unsigned count, input int unsigned read_pct,
	                                     inout int unsigned clears_left);
		request_t    rq;
		int unsigned roll;
		for (int unsigned k = 0; k < count; k++) begin
			rq = REQ_BITS'({$urandom, $urandom, $urandom, $urandom});
			roll = $urandom_range(0, 99);
			if (k == count - 1 || roll < read_pct) begin
				rq.op = e2nwa_pkg::OP_READ;
				rq.node_a = pick_node();
			end else if (roll < read_pct + 4) begin
				rq.op = e2nwa_pkg::OP_ACC;
				case ($urandom_range(0, 4))
					0: rq.corner_count = 3'd0;
					1: rq.corner_count = 3'd1;
					2: rq.corner_count = 3'd5;
					3: rq.corner_count = 3'd6;
					default: rq.corner_count = 3'd7;
				endcase
			end else if (roll < read_pct + 6) begin
				rq.op = OP_SPARE;
			end else if (roll < read_pct + 7 && clears_left != 0) begin
				rq.op = e2nwa_pkg::OP_CLEAR;
				clears_left--;
			end else begin
				rq.op = e2nwa_pkg::OP_ACC;
				rq.corner_count = e2nwa_pkg::CORNER_W'($urandom_range(2, 4));
				rq.node_a = pick_node();
				rq.node_b = pick_node();
				rq.node_c = pick_node();
				rq.node_d = pick_node();
				if ($urandom_range(0, 1) == 0)
					rq.component = '0;
				rq.weight = pick_weight();
				rq.element_value = pick_value();
			end
			queue_request(rq);
		end
	endtask

	// Waits until every request is taken and answered, then lets the block finish up.
	task automatic settle_block();
		while (requests_taken != requests_queued || due_averages.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_component_count(input logic [e2nwa_pkg::CCOUNT_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.component_count <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		model_ccount = value;
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [e2nwa_pkg::CCOUNT_W-1:0] phase_counts [8];
		int unsigned                    clears_left;
		cfg_ch.valid = 1'b0;
		cfg_ch.component_count = '0;
		gaps_on = 1'b1;
		long_hold = 1'b0;
		requests_queued = 0;
		requests_taken = 0;
		mismatches = 0;
		clears_left = 12;
		model_ccount = 3'd1;
		clear_node_stores();
		phase_counts = '{3'd0, 3'd7, 3'd1, 3'd4, 3'd6, 3'd3, 3'd5, 3'd4};
		@(posedge arst_n);

		write_component_count(3'd4);
		// Empty nodes, rejected corner counts, then extreme products and saturation.
		queue_request(build_request(e2nwa_pkg::OP_READ, 3'd2, 10'd0, 10'd0, 10'd0, 10'd0,
		                            2'd0, 0, 0));
		queue_request(build_request(e2nwa_pkg::OP_ACC, 3'd0, 10'd1, 10'd2, 10'd3, 10'd4,
		                            2'd0, 5, 5));
		queue_request(build_request(e2nwa_pkg::OP_ACC, 3'd1, 10'd1, 10'd2, 10'd3, 10'd4,
		                            2'd0, 5, 5));
		queue_request(build_request(e2nwa_pkg::OP_ACC, 3'd5, 10'd1, 10'd2, 10'd3, 10'd4,
		                            2'd0, 5, 5));
		queue_request(build_request(e2nwa_pkg::OP_ACC, 3'd7, 10'h3FF, 10'h3FF, 10'h3FF,
		                            10'h3FF, 2'd3, '1, '1));
		queue_request(build_request(e2nwa_pkg::OP_ACC, 3'd2, 10'd0, 10'd1023, 10'd0, 10'd0,
		                            2'd0, 32'hFFFF_FFFF, 32'h8000_0000));
		queue_request(build_request(e2nwa_pkg::OP_ACC, 3'd4, 10'd5, 10'd5, 10'd5, 10'd5,
		                            2'd0, 32'd1, 32'h7FFF_FFFF));
		queue_request(build_request(e2nwa_pkg::OP_ACC, 3'd3, 10'd2, 10'd3, 10'd4, 10'd0,
		                            2'd0, 32'h0001_8000, 32'h0002_0000));
		queue_request(build_request(e2nwa_pkg::OP_ACC, 3'd3, 10'd2, 10'd3, 10'd4, 10'd0,
		                            2'd1, 32'h0001_8000, 32'hFFFF_0000));
		queue_request(build_request(e2nwa_pkg::OP_ACC, 3'd3, 10'd7, 10'd7, 10'd7, 10'd0,
		                            2'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
		queue_request(build_request(e2nwa_pkg::OP_ACC, 3'd2, 10'd7, 10'd7, 10'd0, 10'd0,
		                            2'd0, 1, 0));
		queue_request(build_request(e2nwa_pkg::OP_ACC, 3'd4, 10'd8, 10'd8, 10'd8, 10'd8,
		                            2'd2, 32'hFFFF_FFFF, 32'h8000_0000));
		queue_request(build_request(e2nwa_pkg::OP_ACC, 3'd2, 10'd8, 10'd9, 10'd0, 10'd0,
		                            2'd0, 32'h0001_0000, 32'd3));
		queue_request(build_request(e2nwa_pkg::OP_ACC, 3'd2, 10'd9, 10'd9, 10'd0, 10'd0,
		                            2'd3, 0, '1));
		queue_request(build_request(e2nwa_pkg::OP_READ, 3'd0, 10'd0, 10'd0, 10'd0, 10'd0,
		                            2'd0, 0, 0));
		queue_request(build_request(e2nwa_pkg::OP_READ, 3'd0, 10'd5, 10'd0, 10'd0, 10'd0,
		                            2'd0, 0, 0));
		queue_request(build_request(e2nwa_pkg::OP_READ, 3'd0, 10'd2, 10'd0, 10'd0, 10'd0,
		                            2'd1, 0, 0));
		queue_request(build_request(e2nwa_pkg::OP_READ, 3'd0, 10'd7, 10'd0, 10'd0, 10'd0,
		                            2'd1, 0, 0));
		queue_request(build_request(e2nwa_pkg::OP_READ, 3'd0, 10'd8, 10'd0, 10'd0, 10'd0,
		                            2'd2, 0, 0));
		queue_request(build_request(e2nwa_pkg::OP_READ, 3'd0, 10'd9, 10'd0, 10'd0, 10'd0,
		                            2'd3, 0, 0));
		queue_request(build_request(e2nwa_pkg::OP_READ, 3'd0, 10'd1023, 10'd0, 10'd0, 10'd0,
		                            2'd0, 0, 0));
		settle_block();

		// With two components, component 3 is ignored on accumulate and reads back as zero.
		write_component_count(3'd2);
		queue_request(build_request(e2nwa_pkg::OP_ACC, 3'd2, 10'd2, 10'd3, 10'd0, 10'd0,
		                            2'd3, 9, 9));
		queue_request(build_request(e2nwa_pkg::OP_READ, 3'd0, 10'd2, 10'd0, 10'd0, 10'd0,
		                            2'd3, 0, 0));
		queue_request(build_request(e2nwa_pkg::OP_READ, 3'd0, 10'd2, 10'd0, 10'd0, 10'd0,
		                            2'd1, 0, 0));
		queue_request(build_request(e2nwa_pkg::OP_CLEAR, 3'd0, 10'd0, 10'd0, 10'd0, 10'd0,
		                            2'd0, 0, 0));
		queue_request(build_request(OP_SPARE, 3'd2, 10'd2, 10'd2, 10'd0, 10'd0, 2'd0, 7, 7));
		queue_request(build_request(e2nwa_pkg::OP_READ, 3'd0, 10'd2, 10'd0, 10'd0, 10'd0,
		                            2'd0, 0, 0));
		settle_block();

		for (int unsigned phase = 0; phase < 8; phase++) begin
			write_component_count(phase_counts[phase]);
			gaps_on <= (phase != 7);
			// The results side holds off for a long stretch while reads pile up behind it.
			if (phase == 2)
				long_hold <= 1'b1;
			queue_random_requests(PHASE_LEN, (phase == 2) ? 70 : 35, clears_left);
			settle_block();
		end

		repeat (50) @(posedge clk);
		if (due_averages.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", due_averages.size()));
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/e2nwa_pkg.sv
rtl/core/e2nwa_if.sv
rtl/core/e2nwa_div.sv
rtl/core/e2nwa_dp.sv
rtl/core/e2nwa_ctrl.sv
rtl/core/element_to_node_weighted_average_core.sv
sim/element_to_node_weighted_average_core_test.sv
